// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under a synchronous active-low reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/lkvc_pkg.sv =====
// Package with the shared types and constants of the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int DATA_W = 32;
    localparam int CAP_W = 5;
    localparam int CMP_W = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OPC_GET = 1'b0;
    localparam logic OPC_SET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RANK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
        logic rank;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic rank_done;
        logic need_rank;
        logic is_get;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/lkvc_ctrl.sv =====
// Controller state machine that sequences the scan, update and response steps.
module lkvc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lkvc_pkg::status_t status,
    output lkvc_pkg::cmd_t    cmd
);
    import lkvc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.need_rank) state_next = ST_RANK;
                else if (status.is_get) state_next = ST_RESP;
                else state_next = ST_IDLE;
            end
            ST_RANK: begin
                if (status.rank_done) state_next = status.is_get ? ST_RESP : ST_IDLE;
            end
            ST_RESP: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            ST_RANK: begin
                cmd.rank = 1'b1;
            end
            ST_RESP: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lkvc_datapath.sv =====
// Datapath with the entry memories, valid bits, scan logic, recency update and output register.
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lkvc_pkg::cmd_t                cmd,
    output lkvc_pkg::status_t             status,
    input  logic                          in_op,
    input  logic [lkvc_pkg::DATA_W-1:0]   in_key,
    input  logic [lkvc_pkg::DATA_W-1:0]   in_val,
    input  logic                          cfg_wr,
    input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic [lkvc_pkg::DATA_W-1:0]   out_value
);
    import lkvc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [DATA_W-1:0] key_mem [ENTRIES];
    logic [DATA_W-1:0] val_mem [ENTRIES];
    logic [IW-1:0]     rank_mem [ENTRIES];
    logic [DATA_W-1:0] key_rd_reg, val_rd_reg;
    logic [IW-1:0]     rank_rd_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg;

    logic [IW:0]   cnt_reg, cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;

    logic              op_reg;
    logic [DATA_W-1:0] key_reg, val_reg;

    logic              hit_reg, hit_next;
    logic [IW-1:0]     match_reg, match_next;
    logic [IW-1:0]     match_rank_reg, match_rank_next;
    logic [DATA_W-1:0] match_val_reg, match_val_next;
    logic              vic_found_reg, vic_found_next;
    logic [IW-1:0]     vic_reg, vic_next;
    logic              free_found_reg, free_found_next;
    logic [IW-1:0]     free_reg, free_next;

    logic [IW-1:0] sel_reg, sel_next;
    logic [IW:0]   thr_reg, thr_next;

    logic              outv_reg;
    logic              outh_reg;
    logic [DATA_W-1:0] outd_reg;

    logic [CMP_W-1:0] eff_cap;
    logic             evict, ins_ok;
    logic [IW-1:0]    slot;
    logic             key_we, val_we, rank_we;
    logic [IW-1:0]    val_waddr;
    logic [IW-1:0]    rank_wdata;
    logic [IW-1:0]    raddr;
    logic             pass_end;

    assign raddr = cnt_reg[IW-1:0];
    assign pass_end = (cnt_reg == (IW+1)'(ENTRIES)) && !rd_vld_reg;

    always_comb begin
        if (cap_reg == '0) eff_cap = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) eff_cap = CMP_W'(ENTRIES);
        else eff_cap = CMP_W'(cap_reg);
    end

    assign evict = (CMP_W'(count_reg) >= eff_cap) && vic_found_reg;
    assign ins_ok = evict || free_found_reg;
    always_comb begin
        if (evict) slot = (free_found_reg && free_reg < vic_reg) ? free_reg : vic_reg;
        else slot = free_reg;
    end

    assign key_we = cmd.decide && (op_reg == OPC_SET) && !hit_reg && ins_ok;
    assign val_we = cmd.decide && (op_reg == OPC_SET) && (hit_reg || ins_ok);
    assign val_waddr = hit_reg ? match_reg : slot;

    always_comb begin
        rank_we = 1'b0;
        rank_wdata = '0;
        if (cmd.rank && rd_vld_reg) begin
            if (rd_idx_reg == sel_reg) begin
                rank_we = 1'b1;
            end else if (valid_reg[rd_idx_reg] && ({1'b0, rank_rd_reg} < thr_reg)) begin
                rank_we = 1'b1;
                rank_wdata = rank_rd_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[slot] <= key_reg;
        if (val_we) val_mem[val_waddr] <= val_reg;
        if (rank_we) rank_mem[rd_idx_reg] <= rank_wdata;
        key_rd_reg <= key_mem[raddr];
        val_rd_reg <= val_mem[raddr];
        rank_rd_reg <= rank_mem[raddr];
    end

    always_comb begin
        cnt_next = cnt_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        if (cmd.start || cmd.decide) begin
            cnt_next = '0;
        end else if ((cmd.scan || cmd.rank) && cnt_reg < (IW+1)'(ENTRIES)) begin
            cnt_next = cnt_reg + (IW+1)'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = raddr;
        end
    end

    always_comb begin
        hit_next = hit_reg;
        match_next = match_reg;
        match_rank_next = match_rank_reg;
        match_val_next = match_val_reg;
        vic_found_next = vic_found_reg;
        vic_next = vic_reg;
        free_found_next = free_found_reg;
        free_next = free_reg;
        if (cmd.start) begin
            hit_next = 1'b0;
            vic_found_next = 1'b0;
            free_found_next = 1'b0;
        end else if (cmd.scan && rd_vld_reg) begin
            if (valid_reg[rd_idx_reg]) begin
                if (!hit_reg && key_rd_reg == key_reg) begin
                    hit_next = 1'b1;
                    match_next = rd_idx_reg;
                    match_rank_next = rank_rd_reg;
                    match_val_next = val_rd_reg;
                end
                if (CW'(rank_rd_reg) == count_reg - CW'(1)) begin
                    vic_found_next = 1'b1;
                    vic_next = rd_idx_reg;
                end
            end else if (!free_found_reg) begin
                free_found_next = 1'b1;
                free_next = rd_idx_reg;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        sel_next = sel_reg;
        thr_next = thr_reg;
        if (cmd.decide) begin
            if ((op_reg == OPC_SET) && !hit_reg) begin
                if (ins_ok) begin
                    if (evict) valid_next[vic_reg] = 1'b0;
                    valid_next[slot] = 1'b1;
                    count_next = count_reg - CW'(evict) + CW'(1);
                end
                sel_next = slot;
                thr_next = (IW+1)'(ENTRIES);
            end else begin
                sel_next = match_reg;
                thr_next = {1'b0, match_rank_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            cap_reg <= CAP_RESET;
            cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            outv_reg <= 1'b0;
            hit_reg <= 1'b0;
            vic_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cfg_wr) cap_reg <= cfg_data;
            cnt_reg <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            hit_reg <= hit_next;
            vic_found_reg <= vic_found_next;
            free_found_reg <= free_found_next;
            if (cmd.out_load) outv_reg <= 1'b1;
            else if (out_ready) outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        match_reg <= match_next;
        match_rank_reg <= match_rank_next;
        match_val_reg <= match_val_next;
        vic_reg <= vic_next;
        free_reg <= free_next;
        sel_reg <= sel_next;
        thr_reg <= thr_next;
        if (cmd.start) begin
            op_reg <= in_op;
            key_reg <= in_key;
            val_reg <= in_val;
        end
        if (cmd.out_load) begin
            outh_reg <= hit_reg;
            outd_reg <= hit_reg ? match_val_reg : '1;
        end
    end

    assign status.scan_done = pass_end;
    assign status.rank_done = pass_end;
    assign status.need_rank = hit_reg || ((op_reg == OPC_SET) && ins_ok);
    assign status.is_get = (op_reg == OPC_GET);
    assign status.out_free = !outv_reg || out_ready;

    assign out_valid = outv_reg;
    assign out_hit = outh_reg;
    assign out_value = outd_reg;

endmodule

// ===== hw/rtl/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: a scan over the entries, then, for a hit or an
// insert, a recency update pass. A new item is accepted only once the previous one is
// finished; a result held by m_tready stalls the next get.
// Reset (synchronous, aresetn low) empties the cache, sets capacity to 16 and drops any result.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lookup_key [31:0], store_value [63:32]
    input  logic [0:0]  s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value [31:0]
    output logic [0:0]  m_tuser,   // hit [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import lkvc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser[0]),
        .in_key    (s_tdata[31:0]),
        .in_val    (s_tdata[63:32]),
        .cfg_wr    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_hit   (m_tuser[0]),
        .out_value (m_tdata)
    );

endmodule

// ===== hw/rtl/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache and its bind to the top level.
`include "assert_macros.svh"

module lkvc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CHK_IMPL(a_miss_value, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 32'hFFFFFFFF)
    `CHK_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind lru_key_value_cache_unit lkvc_checker u_chk (.*);
